// File: src/bpba_pkg.sv
package bpba_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_BLOCKS_DEF    = 256;
    localparam int JOB_SLOTS_DEF     = 16;
    localparam int MAX_SEG_PAGES_DEF = 64;

    // Fixed field widths of the ports.
    localparam int FUNC_W       = 1;
    localparam int JOB_ID_W     = 4;
    localparam int PAGE_COUNT_W = 7;
    localparam int BLOCK_NUM_W  = 8;
    localparam int PAGE_IDX_W   = 6;
    localparam int FREED_W      = 9;
    localparam int STATUS_W     = 2;
    localparam int BLK_COUNT_W  = 9;

    // Reset value of the block count register.
    localparam logic [BLK_COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;

    // Operation codes of an input beat.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_JOB   = 2'd2;

    // One result beat.
    typedef struct packed {
        logic [BLOCK_NUM_W-1:0] block_number;
        logic [PAGE_IDX_W-1:0]  page_index;
        logic [FREED_W-1:0]     freed_count;
        logic [STATUS_W-1:0]    status;
        logic                   last;
    } result_t;

endpackage

// File: src/bpba_ram.sv
module bpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port that holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/bpba_result_stage.sv
module bpba_result_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bpba_pkg::result_t load_data,
    output logic              can_load,
    input  logic              result_stall,
    output logic              result_valid,
    output bpba_pkg::result_t result_data
);

    logic              valid_reg;
    logic              valid_next;
    bpba_pkg::result_t data_reg;

    // A new beat may enter when the slot is empty or is drained this cycle.
    assign can_load = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while the beat is stalled.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

// File: src/bitmap_page_block_allocator_unit.sv
// Bitmap first-fit block allocator.
// Input channel (item_valid / item_stall) carries one request beat: func selects
// allocate or release, job_id names the job, page_count gives the segment size.
// An allocation gives one result beat per page with the block assigned to it; a
// refused, empty or release request gives a single beat. The last flag marks the
// final beat of each request. Results leave through item-independent result_valid
// / result_stall; a one-beat output register lets the next request be taken while
// a result still waits.
// Block used bits and owners live in one single-port-write RAM with a registered
// read. Allocations, releases and block_count recounts walk it one block per
// cycle with the next read overlapped with the current check: an allocation up
// to the effective count or its last page, a release all NUM_BLOCKS blocks, a
// recount the first E blocks, E being block_count saturated to NUM_BLOCKS.
// A stalled result pauses the walk.
// After reset a clearing pass marks every one of the NUM_BLOCKS blocks free; no
// request is taken during it, while block_count writes are taken but for its last step.
module bitmap_page_block_allocator_unit #(
    parameter int NUM_BLOCKS    = bpba_pkg::NUM_BLOCKS_DEF,
    parameter int JOB_SLOTS     = bpba_pkg::JOB_SLOTS_DEF,
    parameter int MAX_SEG_PAGES = bpba_pkg::MAX_SEG_PAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [bpba_pkg::FUNC_W-1:0]        func,
    input  logic [bpba_pkg::JOB_ID_W-1:0]      job_id,
    input  logic [bpba_pkg::PAGE_COUNT_W-1:0]  page_count,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [bpba_pkg::BLOCK_NUM_W-1:0]   block_number,
    output logic [bpba_pkg::PAGE_IDX_W-1:0]    page_index,
    output logic [bpba_pkg::FREED_W-1:0]       freed_count,
    output logic [bpba_pkg::STATUS_W-1:0]      status,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpba_pkg::BLK_COUNT_W-1:0]   block_count
);

    localparam int ADDR_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int OWN_W   = $clog2(JOB_SLOTS);
    localparam int WORD_W  = OWN_W + 1;
    localparam int CMP_W   = (CNT_W > bpba_pkg::BLK_COUNT_W) ? CNT_W : bpba_pkg::BLK_COUNT_W;
    localparam int PG_W    = bpba_pkg::PAGE_COUNT_W;
    localparam int JOB_IDS = 2 ** bpba_pkg::JOB_ID_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ALLOC,
        ST_FREE,
        ST_REPORT,
        ST_COUNT
    } state_t;

    state_t                          state_reg, state_next;
    logic [bpba_pkg::BLK_COUNT_W-1:0] block_count_reg, block_count_next;
    logic [CNT_W-1:0]                free_reg, free_next;
    logic [bpba_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [OWN_W-1:0]                job_reg, job_next;
    logic [PG_W-1:0]                 pages_reg, pages_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    logic                            chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0]               chk_addr_reg, chk_addr_next;
    logic [PG_W-1:0]                 given_reg, given_next;
    logic [CNT_W-1:0]                tally_reg, tally_next;
    logic [JOB_SLOTS-1:0]            job_active_reg, job_active_next;

    logic [OWN_W-1:0]  job_map [JOB_IDS];
    logic [CMP_W-1:0]  bc_wide;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  scan_limit;
    logic              more;
    logic              clear_end;
    logic              cfg_write;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              word_used;
    logic [OWN_W-1:0]  word_owner;

    logic              res_load;
    logic              res_can_load;
    bpba_pkg::result_t res_data;
    bpba_pkg::result_t res_out;
    logic [31:0]       blk_wide;
    logic [31:0]       tally_wide;
    logic              hit;

    // Job id folded into the job slots, one constant entry per possible id.
    for (genvar g = 0; g < JOB_IDS; g++)
    begin : g_job_map
        assign job_map[g] = OWN_W'(g % JOB_SLOTS);
    end

    // Effective block count: the register saturated to the memory depth.
    assign bc_wide   = CMP_W'(block_count_reg);
    assign eff_count = (bc_wide > CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bc_wide);

    // A release walks every block; allocation and recount stop at the count.
    assign scan_limit = (state_reg == ST_FREE) ? CNT_W'(NUM_BLOCKS) : eff_count;
    assign more       = scan_reg < scan_limit;
    assign clear_end  = scan_reg == CNT_W'(NUM_BLOCKS - 1);

    assign cfg_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_CLEAR) && !clear_end);
    assign cfg_write  = cfg_valid && cfg_ready;
    assign item_stall = (state_reg != ST_IDLE) || cfg_valid;

    assign word_used  = ram_rdata[OWN_W];
    assign word_owner = ram_rdata[OWN_W-1:0];
    assign blk_wide   = 32'(chk_addr_reg);
    assign tally_wide = 32'(tally_reg);

    // Sequencer: request decode, block walk and result generation.
    always_comb
    begin
        state_next       = state_reg;
        block_count_next = block_count_reg;
        free_next        = free_reg;
        func_next        = func_reg;
        job_next         = job_reg;
        pages_next       = pages_reg;
        scan_next        = scan_reg;
        chk_valid_next   = chk_valid_reg;
        chk_addr_next    = chk_addr_reg;
        given_next       = given_reg;
        tally_next       = tally_reg;
        job_active_next  = job_active_reg;
        ram_we           = 1'b0;
        ram_waddr        = chk_addr_reg;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = scan_reg[ADDR_W-1:0];
        res_load         = 1'b0;
        res_data         = '0;
        hit              = 1'b0;

        if (cfg_write)
        begin
            block_count_next = block_count;
        end

        case (state_reg)
            // Clearing pass: mark each block free, one per cycle.
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[ADDR_W-1:0];
                scan_next = scan_reg + CNT_W'(1);
                if (clear_end)
                begin
                    free_next  = eff_count;
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cfg_write)
                begin
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    tally_next     = '0;
                    state_next     = ST_COUNT;
                end
                else if (item_valid)
                begin
                    func_next  = func;
                    job_next   = job_map[job_id];
                    pages_next = page_count;
                    state_next = ST_START;
                end
            end

            // Decide whether the request walks the memory or answers at once.
            ST_START:
            begin
                scan_next      = '0;
                chk_valid_next = 1'b0;
                given_next     = '0;
                tally_next     = '0;
                if (func_reg == bpba_pkg::FUNC_ALLOC)
                begin
                    if ((pages_reg > PG_W'(MAX_SEG_PAGES)) ||
                        (32'(pages_reg) > 32'(free_reg)))
                    begin
                        res_data.status = bpba_pkg::STATUS_NO_SPACE;
                        res_data.last   = 1'b1;
                        if (res_can_load)
                        begin
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (pages_reg == '0)
                    begin
                        res_data.status = bpba_pkg::STATUS_OK;
                        res_data.last   = 1'b1;
                        if (res_can_load)
                        begin
                            res_load                 = 1'b1;
                            job_active_next[job_reg] = 1'b1;
                            state_next               = ST_IDLE;
                        end
                    end
                    else
                    begin
                        job_active_next[job_reg] = 1'b1;
                        state_next               = ST_ALLOC;
                    end
                end
                else if (!job_active_reg[job_reg])
                begin
                    res_data.status = bpba_pkg::STATUS_NO_JOB;
                    res_data.last   = 1'b1;
                    if (res_can_load)
                    begin
                        res_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_FREE;
                end
            end

            // First fit: each free block checked is taken for the next page.
            ST_ALLOC:
            begin
                hit = chk_valid_reg && !word_used;
                res_data.block_number = blk_wide[bpba_pkg::BLOCK_NUM_W-1:0];
                res_data.page_index   = given_reg[bpba_pkg::PAGE_IDX_W-1:0];
                res_data.status       = bpba_pkg::STATUS_OK;
                res_data.last         = (given_reg + PG_W'(1)) == pages_reg;
                if (!(hit && !res_can_load))
                begin
                    if (hit)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {1'b1, job_reg};
                        res_load   = 1'b1;
                        given_next = given_reg + PG_W'(1);
                        free_next  = free_reg - CNT_W'(1);
                    end
                    if (hit && res_data.last)
                    begin
                        chk_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else if (more)
                    begin
                        ram_re         = 1'b1;
                        chk_valid_next = 1'b1;
                        chk_addr_next  = scan_reg[ADDR_W-1:0];
                        scan_next      = scan_reg + CNT_W'(1);
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                        if (!chk_valid_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            // Release: clear every used block owned by the job.
            ST_FREE:
            begin
                hit = chk_valid_reg && word_used && (word_owner == job_reg);
                if (hit)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {1'b0, word_owner};
                    tally_next = tally_reg + CNT_W'(1);
                    if (CNT_W'(chk_addr_reg) < eff_count)
                    begin
                        free_next = free_reg + CNT_W'(1);
                    end
                end
                if (more)
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end

            ST_REPORT:
            begin
                res_data.freed_count = tally_wide[bpba_pkg::FREED_W-1:0];
                res_data.status      = bpba_pkg::STATUS_OK;
                res_data.last        = 1'b1;
                if (res_can_load)
                begin
                    res_load                 = 1'b1;
                    job_active_next[job_reg] = 1'b0;
                    state_next               = ST_IDLE;
                end
            end

            // Recount free blocks below the new block count.
            ST_COUNT:
            begin
                hit = chk_valid_reg && !word_used;
                if (hit)
                begin
                    tally_next = tally_reg + CNT_W'(1);
                end
                if (more)
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        free_next  = tally_next;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            block_count_reg <= bpba_pkg::BLOCK_COUNT_RESET;
            free_reg        <= '0;
            func_reg        <= bpba_pkg::FUNC_ALLOC;
            job_reg         <= '0;
            pages_reg       <= '0;
            scan_reg        <= '0;
            chk_valid_reg   <= 1'b0;
            chk_addr_reg    <= '0;
            given_reg       <= '0;
            tally_reg       <= '0;
            job_active_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            free_reg        <= free_next;
            func_reg        <= func_next;
            job_reg         <= job_next;
            pages_reg       <= pages_next;
            scan_reg        <= scan_next;
            chk_valid_reg   <= chk_valid_next;
            chk_addr_reg    <= chk_addr_next;
            given_reg       <= given_next;
            tally_reg       <= tally_next;
            job_active_reg  <= job_active_next;
        end
    end

    // Used bit and owner of each block.
    bpba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_BLOCKS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register between the walk and the result channel.
    bpba_result_stage u_result_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .load_data    (res_data),
        .can_load     (res_can_load),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (res_out)
    );

    assign block_number = res_out.block_number;
    assign page_index   = res_out.page_index;
    assign freed_count  = res_out.freed_count;
    assign status       = res_out.status;
    assign last         = res_out.last;

endmodule

// File: tb/bitmap_page_block_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_page_block_allocator_unit_tb;

    localparam int NBLK      = bpba_pkg::NUM_BLOCKS_DEF;
    localparam int NJOB      = bpba_pkg::JOB_SLOTS_DEF;
    localparam int SEG_MAX   = bpba_pkg::MAX_SEG_PAGES_DEF;
    localparam int QUIET_MAX = 4000;

    logic                                clk;
    logic                                rst_n        = 1'b0;
    logic                                item_valid   = 1'b0;
    logic                                item_stall;
    logic [bpba_pkg::FUNC_W-1:0]         func         = bpba_pkg::FUNC_ALLOC;
    logic [bpba_pkg::JOB_ID_W-1:0]       job_id       = '0;
    logic [bpba_pkg::PAGE_COUNT_W-1:0]   page_count   = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic [bpba_pkg::BLOCK_NUM_W-1:0]    block_number;
    logic [bpba_pkg::PAGE_IDX_W-1:0]     page_index;
    logic [bpba_pkg::FREED_W-1:0]        freed_count;
    logic [bpba_pkg::STATUS_W-1:0]       status;
    logic                                last;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [bpba_pkg::BLK_COUNT_W-1:0]    block_count  = bpba_pkg::BLOCK_COUNT_RESET;

    bitmap_page_block_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .job_id       (job_id),
        .page_count   (page_count),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .block_number (block_number),
        .page_index   (page_index),
        .freed_count  (freed_count),
        .status       (status),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .block_count  (block_count)
    );

    // Shadow copy of the allocator state.
    bit                            blk_used  [NBLK];
    logic [bpba_pkg::JOB_ID_W-1:0] blk_owner [NBLK];
    bit                            job_live  [NJOB];
    int unsigned                   free_blocks;
    int unsigned                   count_reg;

    // Result beats still owed by the block, oldest first.
    bpba_pkg::result_t pending_beats[$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int mismatches    = 0;
    int n_alloc       = 0;
    int n_release     = 0;
    int n_beats       = 0;
    int n_cfg         = 0;
    int n_no_space    = 0;
    int n_no_job      = 0;
    int quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned usable_blocks();
        return (count_reg > NBLK) ? NBLK : count_reg;
    endfunction

    function automatic void recount_free();
        free_blocks = 0;
        for (int b = 0; b < usable_blocks(); b++)
        begin
            if (!blk_used[b])
                free_blocks++;
        end
    endfunction

    // Work out the beats one accepted request causes and update the shadow state.
    function automatic void predict_request(input logic [bpba_pkg::FUNC_W-1:0] f,
                                            input logic [bpba_pkg::JOB_ID_W-1:0] j,
                                            input logic [bpba_pkg::PAGE_COUNT_W-1:0] p);
        bpba_pkg::result_t beat;
        int unsigned       lim;
        int unsigned       given;
        int unsigned       freed;
        lim = usable_blocks();
        beat = '0;
        beat.last = 1'b1;
        if (f == bpba_pkg::FUNC_ALLOC)
        begin
            if (p > SEG_MAX || p > free_blocks)
            begin
                beat.status = bpba_pkg::STATUS_NO_SPACE;
                pending_beats.push_back(beat);
                n_no_space++;
            end
            else
            begin
                job_live[j] = 1'b1;
                if (p == 0)
                begin
                    pending_beats.push_back(beat);
                end
                else
                begin
                    // First fit from block zero upward, one beat per page.
                    given = 0;
                    for (int b = 0; b < lim && given < p; b++)
                    begin
                        if (!blk_used[b])
                        begin
                            blk_used[b] = 1'b1;
                            blk_owner[b] = j;
                            beat.block_number = 8'(b);
                            beat.page_index = 6'(given);
                            beat.last = (given + 1 == p);
                            pending_beats.push_back(beat);
                            given++;
                        end
                    end
                    free_blocks -= given;
                end
            end
        end
        else if (!job_live[j])
        begin
            beat.status = bpba_pkg::STATUS_NO_JOB;
            pending_beats.push_back(beat);
            n_no_job++;
        end
        else
        begin
            // Blocks past the usable count are freed but do not return to the pool.
            freed = 0;
            for (int b = 0; b < NBLK; b++)
            begin
                if (blk_used[b] && blk_owner[b] == j)
                begin
                    blk_used[b] = 1'b0;
                    freed++;
                    if (b < lim)
                        free_blocks++;
                end
            end
            job_live[j] = 1'b0;
            beat.freed_count = 9'(freed);
            pending_beats.push_back(beat);
        end
    endfunction

    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, name,
                         want, got);
        end
    endfunction

    // Random stall on the result side.
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < sink_stall_pct);

    // Compare every accepted result beat with the oldest one owed.
    always @(posedge clk)
    begin : result_check
        bpba_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            n_beats++;
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected no beat, got block %0d page %0d",
                             $realtime, block_number, page_index);
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("block_number", 9'(want.block_number), 9'(block_number));
                check_field("page_index", 9'(want.page_index), 9'(page_index));
                check_field("freed_count", want.freed_count, freed_count);
                check_field("status", 9'(want.status), 9'(status));
                check_field("last", 9'(want.last), 9'(last));
            end
        end
    end

    // Watchdog: too long without any beat moving on any channel.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one request beat, idling first at random, and predict it once taken.
    task automatic send_request(input logic [bpba_pkg::FUNC_W-1:0] f,
                                input logic [bpba_pkg::JOB_ID_W-1:0] j,
                                input logic [bpba_pkg::PAGE_COUNT_W-1:0] p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func       <= f;
        job_id     <= j;
        page_count <= p;
        do
            @(posedge clk);
        while (item_stall);
        if (f == bpba_pkg::FUNC_ALLOC)
            n_alloc++;
        else
            n_release++;
        predict_request(f, j, p);
    endtask

    // Stop offering requests and wait until every owed beat has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    task automatic write_block_count(input logic [bpba_pkg::BLK_COUNT_W-1:0] value);
        drain_results();
        cfg_valid   <= 1'b1;
        block_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg = value;
        recount_free();
        n_cfg++;
    endtask

    // Empty, full-size, oversized, repeat and unknown-job requests at the reset count.
    task automatic test_directed_segments();
        write_block_count(9'd256);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd0, 7'd0);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd0, 7'd0);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd5, 7'd127);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd15, 7'd64);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd1, 7'd65);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd1, 7'd127);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd2, 7'd3);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd15, 7'd2);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd15, 7'd0);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd3, 7'd5);
    endtask

    // Shrinking the count below used blocks, a zero count, saturation and a single block.
    task automatic test_block_count_edges();
        write_block_count(9'd8);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd4, 7'd4);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd4, 7'd3);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd10, 7'd1);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd2, 7'd0);
        write_block_count(9'd0);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd6, 7'd1);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd6, 7'd0);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd3, 7'd0);
        write_block_count(9'd511);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd7, 7'd64);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd4, 7'd0);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd6, 7'd0);
        write_block_count(9'd1);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd8, 7'd1);
        send_request(bpba_pkg::FUNC_ALLOC, 4'd9, 7'd1);
        send_request(bpba_pkg::FUNC_RELEASE, 4'd8, 7'd0);
    endtask

    // Mostly allocations and releases of live jobs, with some noise on top.
    task automatic test_random_traffic(input logic [bpba_pkg::BLK_COUNT_W-1:0] count,
                                       input int src_pct, input int sink_pct,
                                       input int n_items);
        int unsigned                       pick;
        int unsigned                       size_pick;
        logic [bpba_pkg::JOB_ID_W-1:0]     j;
        logic [bpba_pkg::PAGE_COUNT_W-1:0] p;
        logic [bpba_pkg::JOB_ID_W-1:0]     live[$];
        write_block_count(count);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            j = bpba_pkg::JOB_ID_W'($urandom_range(NJOB - 1));
            p = bpba_pkg::PAGE_COUNT_W'($urandom_range(127));
            if (pick < 50)
            begin
                size_pick = $urandom_range(99);
                if (size_pick < 8)
                    p = '0;
                else if (size_pick < 78)
                    p = bpba_pkg::PAGE_COUNT_W'($urandom_range(12, 1));
                else if (size_pick < 92)
                    p = bpba_pkg::PAGE_COUNT_W'($urandom_range(64, 13));
                else
                    p = bpba_pkg::PAGE_COUNT_W'($urandom_range(127, 65));
                send_request(bpba_pkg::FUNC_ALLOC, j, p);
            end
            else
            begin
                if (pick < 88)
                begin
                    live.delete();
                    for (int k = 0; k < NJOB; k++)
                    begin
                        if (job_live[k])
                            live.push_back(bpba_pkg::JOB_ID_W'(k));
                    end
                    if (live.size() != 0)
                        j = live[$urandom_range(live.size() - 1)];
                end
                send_request(bpba_pkg::FUNC_RELEASE, j, p);
            end
        end
        drain_results();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    initial
    begin
        count_reg = bpba_pkg::BLOCK_COUNT_RESET;
        recount_free();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_segments();
        test_block_count_edges();
        test_random_traffic(9'd256, 0, 0, 77);
        test_random_traffic(9'($urandom_range(255, 32)), 74, 0, 77);
        test_random_traffic(9'($urandom_range(31, 2)), 0, 74, 77);
        test_random_traffic(9'd256, 36, 36, 77);

        // Let any stray beat show up before the verdict.
        drain_results();
        repeat (NBLK + 16) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            $display("%0d result beats never arrived", pending_beats.size());
            mismatches += pending_beats.size();
        end

        $display("covered %0d requests (%0d alloc, %0d release), %0d beats, %0d count writes",
                 n_alloc + n_release, n_alloc, n_release, n_beats, n_cfg);
        $display("refused %0d for lack of space and %0d for an idle job; %0d mismatches",
                 n_no_space, n_no_job, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
src/bpba_pkg.sv
src/bpba_ram.sv
src/bpba_result_stage.sv
src/bitmap_page_block_allocator_unit.sv
tb/bitmap_page_block_allocator_unit_tb.sv
